// ----- src/fgr_pkg.sv -----
// fgr_pkg: shared constants for the four-gamete minimum recombination block
// used by fgr_front, fgr_back and the top level; no dependencies
package fgr_pkg;

  localparam int DEF_MAX_SITES   = 1024;
  localparam int DEF_MAX_SAMPLES = 64;

  localparam int COL_W      = 64;
  localparam int CNT_W      = 7;
  localparam int RECOMB_W   = 10;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 2;

  localparam logic [CNT_W-1:0]    SAMPLE_COUNT_RST = 7'd64;
  localparam logic [RECOMB_W-1:0] RECOMB_MAX       = 10'd1023;

endpackage

// ----- src/fgr_front.sv -----
// fgr_front: sample count register, input masking and push into the site queue
// depends on fgr_pkg
module fgr_front #(
  parameter int MAX_SAMPLES = fgr_pkg::DEF_MAX_SAMPLES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [fgr_pkg::CNT_W-1:0]   cfg_wr_data,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [fgr_pkg::COL_W-1:0]   in_tdata,
  input  logic                        in_tlast,
  input  logic                        q_full,
  output logic                        q_push,
  output logic [2*MAX_SAMPLES:0]      q_wdata
);
  import fgr_pkg::*;

  logic [CNT_W-1:0]       sample_count_r;
  logic [CNT_W-1:0]       n_sat;
  logic [MAX_SAMPLES-1:0] mask;
  logic [MAX_SAMPLES-1:0] col;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= SAMPLE_COUNT_RST;
    end else if (cfg_wr_en) begin
      sample_count_r <= cfg_wr_data;
    end
  end

  // counts above the sample capacity saturate; 0 and 1 pass as given
  assign n_sat = (sample_count_r > CNT_W'(MAX_SAMPLES)) ? CNT_W'(MAX_SAMPLES)
                                                         : sample_count_r;

  always_comb begin
    for (int i = 0; i < MAX_SAMPLES; i++) begin
      mask[i] = (CNT_W'(i) < n_sat);
    end
  end

  assign col       = in_tdata[MAX_SAMPLES-1:0] & mask;
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;
  // the mask travels with the site so the back end tests with the mask of arrival
  assign q_wdata   = {in_tlast, mask, col};

endmodule

// ----- src/fgr_queue.sv -----
// fgr_queue: two-entry queue between the front and back of the block
// no dependencies
module fgr_queue #(
  parameter int W = 129
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         not_empty,
  output logic [W-1:0] rdata
);
  logic [W-1:0] slot_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign rdata     = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- src/fgr_back.sv -----
// fgr_back: column store, window scan with four-gamete test, result register
// depends on fgr_pkg
module fgr_back #(
  parameter int MAX_SITES   = fgr_pkg::DEF_MAX_SITES,
  parameter int MAX_SAMPLES = fgr_pkg::DEF_MAX_SAMPLES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_not_empty,
  input  logic [2*MAX_SAMPLES:0]            q_rdata,
  output logic                              q_pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [fgr_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [fgr_pkg::OUT_USER_W-1:0]    out_tuser
);
  import fgr_pkg::*;

  localparam int AW = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
  localparam int SW = AW + 1;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_COMMIT, ST_EMIT} state_t;

  logic [MAX_SAMPLES-1:0] mem [MAX_SITES];
  logic [MAX_SAMPLES-1:0] rd_data_r;
  logic [AW-1:0]          rd_addr;
  logic                   wr_en;

  state_t                 state_r, state_nxt;
  logic [MAX_SAMPLES-1:0] cur_col_r, cur_col_nxt;
  logic [MAX_SAMPLES-1:0] cur_mask_r, cur_mask_nxt;
  logic                   cur_last_r, cur_last_nxt;
  logic [AW-1:0]          scan_idx_r, scan_idx_nxt;
  logic [AW-1:0]          window_r, window_nxt;
  logic [SW-1:0]          sites_r, sites_nxt;
  logic [RECOMB_W-1:0]    recomb_r, recomb_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [RECOMB_W-1:0]    out_recomb_r, out_recomb_nxt;
  logic                   out_few_r, out_few_nxt;
  logic                   out_ovf_r, out_ovf_nxt;

  logic                   store_full;
  logic                   four_gam;
  logic [MAX_SAMPLES-1:0] p, q, m;

  assign store_full = (sites_r >= SW'(MAX_SITES));

  assign p = rd_data_r;
  assign q = cur_col_r;
  assign m = cur_mask_r;
  assign four_gam = ((~p & ~q & m) != '0) && ((~p & q & m) != '0) &&
                    ((p & ~q & m) != '0) && ((p & q & m) != '0);

  assign rd_addr = (state_r == ST_SCAN) ? scan_idx_r + AW'(1) : window_r;
  assign wr_en   = (state_r == ST_COMMIT) && !store_full;
  assign q_pop   = (state_r == ST_IDLE) && q_not_empty;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[sites_r[AW-1:0]] <= cur_col_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    cur_col_nxt    = cur_col_r;
    cur_mask_nxt   = cur_mask_r;
    cur_last_nxt   = cur_last_r;
    scan_idx_nxt   = scan_idx_r;
    window_nxt     = window_r;
    sites_nxt      = sites_r;
    recomb_nxt     = recomb_r;
    ovf_nxt        = ovf_r;
    out_valid_nxt  = out_valid_r;
    out_recomb_nxt = out_recomb_r;
    out_few_nxt    = out_few_r;
    out_ovf_nxt    = out_ovf_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (q_not_empty) begin
          cur_col_nxt  = q_rdata[MAX_SAMPLES-1:0];
          cur_mask_nxt = q_rdata[2*MAX_SAMPLES-1:MAX_SAMPLES];
          cur_last_nxt = q_rdata[2*MAX_SAMPLES];
          scan_idx_nxt = window_r;
          // empty window or full store: nothing to compare
          if (store_full || ({1'b0, window_r} == sites_r)) begin
            state_nxt = ST_COMMIT;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (four_gam) begin
          if (recomb_r < RECOMB_MAX) begin
            recomb_nxt = recomb_r + RECOMB_W'(1);
          end
          window_nxt = sites_r[AW-1:0];
          state_nxt  = ST_COMMIT;
        end else if (({1'b0, scan_idx_r} + SW'(1)) == sites_r) begin
          state_nxt = ST_COMMIT;
        end else begin
          scan_idx_nxt = scan_idx_r + AW'(1);
        end
      end
      ST_COMMIT: begin
        if (store_full) begin
          ovf_nxt = 1'b1;
        end else begin
          sites_nxt = sites_r + SW'(1);
        end
        state_nxt = cur_last_r ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_few_nxt    = (sites_r < SW'(2));
          out_recomb_nxt = (sites_r < SW'(2)) ? '0 : recomb_r;
          out_ovf_nxt    = ovf_r;
          window_nxt     = '0;
          sites_nxt      = '0;
          recomb_nxt     = '0;
          ovf_nxt        = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      window_r    <= '0;
      sites_r     <= '0;
      recomb_r    <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      window_r    <= window_nxt;
      sites_r     <= sites_nxt;
      recomb_r    <= recomb_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_col_r    <= cur_col_nxt;
    cur_mask_r   <= cur_mask_nxt;
    cur_last_r   <= cur_last_nxt;
    scan_idx_r   <= scan_idx_nxt;
    out_recomb_r <= out_recomb_nxt;
    out_few_r    <= out_few_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-RECOMB_W){1'b0}}, out_recomb_r};
  assign out_tuser  = {out_ovf_r, out_few_r};

endmodule

// ----- src/four_gamete_min_recombination.sv -----
// four_gamete_min_recombination: top level of the minimum recombination counter
// depends on fgr_pkg, fgr_front, fgr_queue, fgr_back
//
//  channel   dir  handshake           payload
//  in_*      in   tvalid/tready       tdata[63:0] column_bits, tlast last_site
//  out_*     out  tvalid/tready       tdata[9:0] recomb_min, tuser[1:0] flags
//  cfg_*     in   wr_en               wr_data[6:0] sample_count
//
// each site is tested against the window columns in turn, between the idle and
// commit states; the single read port of the column store sets the scan length.
// a final site adds an emit state to load the result, held while the last result is untaken.
// reset is synchronous, active low, and leaves no clearing pass to run.
// a two-entry queue takes input while the back end scans or the result waits.
module four_gamete_min_recombination #(
  parameter int MAX_SITES   = fgr_pkg::DEF_MAX_SITES,
  parameter int MAX_SAMPLES = fgr_pkg::DEF_MAX_SAMPLES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [fgr_pkg::CNT_W-1:0]      cfg_wr_data,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [fgr_pkg::COL_W-1:0]      in_tdata,   // [63:0] column_bits
  input  logic                           in_tlast,   // last_site
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [fgr_pkg::OUT_DATA_W-1:0] out_tdata,  // [9:0] recomb_min, rest zero
  output logic [fgr_pkg::OUT_USER_W-1:0] out_tuser   // [0] too_few_sites, [1] sites_overflow
);

  localparam int QW = 2 * MAX_SAMPLES + 1;

  logic          q_full;
  logic          q_push;
  logic [QW-1:0] q_wdata;
  logic          q_pop;
  logic          q_not_empty;
  logic [QW-1:0] q_rdata;

  fgr_front #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_wdata     (q_wdata)
  );

  fgr_queue #(
    .W (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  fgr_back #(
    .MAX_SITES   (MAX_SITES),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule
